/* rtl/stct_pkg.sv */
`default_nettype none

package stct_pkg;

  // Field widths
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SIZE_W     = 20;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned OUT_CNT_W  = 5;

  // Table depth default
  localparam int unsigned ENTRIES_DEF = 16;

  // Configuration port
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;
  localparam logic        REG_SIZE_LIMIT = 1'b0;  // register index, paddr[2]
  localparam logic [TOTAL_W-1:0] SIZE_LIMIT_RESET = 24'd512000;  // 32000 MB

  // Operation codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TRIM   = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture request fields, clear per-request flags
    logic insert;     // insert or reject the captured entry
    logic trim_step;  // drop the largest-time entry
    logic publish;    // load the result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic trim_more;  // table not empty and total above the limit
  } stat_t;

endpackage

`default_nettype wire

/* rtl/stct_if.sv */
`default_nettype none

// Request channel
interface stct_in_if;
  import stct_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] new_time;
  logic [SIZE_W-1:0] new_size;

  modport source (output valid, kind, new_time, new_size, input ready);
  modport sink   (input valid, kind, new_time, new_size, output ready);
endinterface

// Result channel
interface stct_out_if;
  import stct_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TOTAL_W-1:0]   total_size;
  logic [OUT_CNT_W-1:0] entry_total;
  logic [OUT_CNT_W-1:0] removed_count;
  logic                 rejected;

  modport source (output valid, total_size, entry_total, removed_count, rejected,
                  input ready);
  modport sink   (input valid, total_size, entry_total, removed_count, rejected,
                  output ready);
endinterface

`default_nettype wire

/* rtl/stct_ctrl.sv */
`default_nettype none

module stct_ctrl
  import stct_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_kind_i,
  output logic       in_ready_o,
  input  wire logic  out_ready_i,
  output logic       out_valid_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_TRIM,
    S_FIN
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_acc;
  logic   out_free;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  // Commands decoded from the current state
  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = in_acc;
    cmd_o.insert    = (state_q == S_INS);
    cmd_o.trim_step = (state_q == S_TRIM) && stat_i.trim_more;
    cmd_o.publish   = (state_q == S_FIN) && out_free;
  end

  // Sequencer and result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= (in_kind_i == KIND_TRIM) ? S_TRIM : S_INS;
          end
        end
        S_INS: begin
          state_q <= S_FIN;
        end
        S_TRIM: begin
          if (!stat_i.trim_more) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/stct_dpath.sv */
`default_nettype none

// Cell chain is stored tail first: cell 0 holds the largest time key,
// so a trim always reads cell 0 and shifts the chain down by one.
module stct_dpath
  import stct_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output stat_t                     stat_o,
  input  wire logic [TIME_W-1:0]    new_time_i,
  input  wire logic [SIZE_W-1:0]    new_size_i,
  input  wire logic [TOTAL_W-1:0]   size_limit_i,
  output logic [TOTAL_W-1:0]        total_size_o,
  output logic [OUT_CNT_W-1:0]      entry_total_o,
  output logic [OUT_CNT_W-1:0]      removed_count_o,
  output logic                      rejected_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  logic [TIME_W-1:0]  cell_time_q [ENTRIES];
  logic [SIZE_W-1:0]  cell_size_q [ENTRIES];
  logic [TIME_W-1:0]  cell_time_d [ENTRIES];
  logic [SIZE_W-1:0]  cell_size_d [ENTRIES];
  logic [ENTRIES-1:0] ge;

  logic [CNT_W-1:0]   count_q;
  logic [TOTAL_W-1:0] total_q;
  logic [TIME_W-1:0]  req_time_q;
  logic [SIZE_W-1:0]  req_size_q;
  logic [CNT_W-1:0]   removed_q;
  logic               rej_q;

  logic [TOTAL_W:0]   ins_sum;
  logic               full;
  logic               rej;
  logic               cell_we;

  logic [TOTAL_W-1:0]   res_total_q;
  logic [OUT_CNT_W-1:0] res_count_q;
  logic [OUT_CNT_W-1:0] res_removed_q;
  logic                 res_rej_q;

  // Insert checks: table full or total overflow
  assign ins_sum = {1'b0, total_q} + (TOTAL_W + 1)'(req_size_q);
  assign full    = (count_q == CNT_W'(ENTRIES));
  assign rej     = full || ins_sum[TOTAL_W];

  assign stat_o.trim_more = (count_q != '0) && (total_q > size_limit_i);

  // Occupied cells with a key at or above the new key (a prefix from cell 0)
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ge[i] = (CNT_W'(i) < count_q) && (cell_time_q[i] >= req_time_q);
    end
  end

  // Next cell contents: open a slot on insert, shift down on trim
  always_comb begin
    cell_time_d = cell_time_q;
    cell_size_d = cell_size_q;
    if (cmd_i.insert) begin
      if (!ge[0]) begin
        cell_time_d[0] = req_time_q;
        cell_size_d[0] = req_size_q;
      end
      for (int i = 1; i < ENTRIES; i++) begin
        if (!ge[i]) begin
          if (ge[i-1]) begin
            cell_time_d[i] = req_time_q;
            cell_size_d[i] = req_size_q;
          end else begin
            cell_time_d[i] = cell_time_q[i-1];
            cell_size_d[i] = cell_size_q[i-1];
          end
        end
      end
    end else begin
      for (int i = 0; i < ENTRIES - 1; i++) begin
        cell_time_d[i] = cell_time_q[i+1];
        cell_size_d[i] = cell_size_q[i+1];
      end
    end
  end

  assign cell_we = (cmd_i.insert && !rej) || cmd_i.trim_step;

  // Cell chain storage
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_time_q <= cell_time_d;
      cell_size_q <= cell_size_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_time_q <= new_time_i;
      req_size_q <= new_size_i;
    end
  end

  // Count, total and per-request flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      total_q   <= '0;
      removed_q <= '0;
      rej_q     <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        removed_q <= '0;
        rej_q     <= 1'b0;
      end else if (cmd_i.insert) begin
        rej_q <= rej;
        if (!rej) begin
          count_q <= count_q + CNT_W'(1);
          total_q <= ins_sum[TOTAL_W-1:0];
        end
      end else if (cmd_i.trim_step) begin
        count_q   <= count_q - CNT_W'(1);
        total_q   <= total_q - TOTAL_W'(cell_size_q[0]);
        removed_q <= removed_q + CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      res_total_q   <= total_q;
      res_count_q   <= OUT_CNT_W'(count_q);
      res_removed_q <= OUT_CNT_W'(removed_q);
      res_rej_q     <= rej_q;
    end
  end

  assign total_size_o    = res_total_q;
  assign entry_total_o   = res_count_q;
  assign removed_count_o = res_removed_q;
  assign rejected_o      = res_rej_q;

endmodule

`default_nettype wire

/* rtl/sorted_table_capacity_trim.sv */
`default_nettype none

// Sorted table with capacity trim. Holds up to ENTRIES entries (time key, size)
// in ascending time order plus a running size total, in 1/16 MB units. An
// insert request places its entry ahead of all entries with an equal or larger
// key, or is rejected when the table is full or the total would overflow 24
// bits. A trim request drops largest-key entries until the total is at most
// size_limit or the table is empty. Every request yields one result. The table
// is a shifting cell chain: an insert passes S_INS and S_FIN before its result
// is valid; a trim removes entries one per cycle through the tail cell, then
// enters S_FIN. A new request is taken while a result waits in the output
// register. size_limit sits at APB byte address 0 (reset 512000, i.e. 32000 MB);
// the user must write it only while no request is in flight; the block won't check.
module sorted_table_capacity_trim_core
  import stct_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  stct_in_if.sink                    in_i,
  stct_out_if.source                 out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cmd_t               cmd;
  stat_t              stat;
  logic [TOTAL_W-1:0] size_limit_q;
  logic               reg_sel;

  // Register file: one register, size_limit
  assign reg_sel = (paddr[2] == REG_SIZE_LIMIT);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_W'(size_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_limit_q <= SIZE_LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      size_limit_q <= pwdata[TOTAL_W-1:0];
    end
  end

  stct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stct_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .new_time_i      (in_i.new_time),
    .new_size_i      (in_i.new_size),
    .size_limit_i    (size_limit_q),
    .total_size_o    (out_o.total_size),
    .entry_total_o   (out_o.entry_total),
    .removed_count_o (out_o.removed_count),
    .rejected_o      (out_o.rejected)
  );

  // A result still waiting is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !(out_o.valid && !out_o.ready))
    else $error("result register overwritten while held");

  // An accepted request keeps the input closed for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input reopened right after accept");

  // A rejected insert never reports removals
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.rejected) |-> (out_o.removed_count == '0))
    else $error("rejected result carries a removed count");

  // Only one command at a time reaches the datapath
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.insert, cmd.trim_step, cmd.publish}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire
